@@ rtl/blr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blr_pkg - shared types and constants for the line rasterizer
// Status and action codes, register indexes, default widths.
// ----------------------------------------------------------------------------
package blr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int COLOR_BITS_DEF = 16;
    localparam int OFFSET_BITS    = 24;
    localparam int CFG_INDEX_BITS = 1;
    localparam int WIDTH_RESET    = 640;
    localparam int HEIGHT_RESET   = 480;

    typedef enum logic [1:0] {
        ST_PIXEL  = 2'd0,
        ST_REJECT = 2'd1,
        ST_IDLE   = 2'd2
    } status_t;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_STEP = 1'b1
    } action_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        status_t status;
        logic    last;
    } pix_ctrl_t;

endpackage

@@ rtl/blr_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blr_if - valid/ready channels of the line rasterizer
// Command channel (load / step) and pixel result channel.
// ----------------------------------------------------------------------------
interface blr_cmd_if #(
    parameter int COORD_BITS = 12,
    parameter int COLOR_BITS = 16
) ();
    logic                  valid;
    logic                  ready;
    logic                  action;
    logic [COORD_BITS:0]   start_x;
    logic [COORD_BITS:0]   start_y;
    logic [COORD_BITS:0]   end_x;
    logic [COORD_BITS:0]   end_y;
    logic [COLOR_BITS-1:0] color;

    modport source (output valid, action, start_x, start_y, end_x, end_y, color,
                    input ready);
    modport sink   (input valid, action, start_x, start_y, end_x, end_y, color,
                    output ready);
endinterface

interface blr_pix_if #(
    parameter int COORD_BITS = 12,
    parameter int COLOR_BITS = 16
) ();
    import blr_pkg::*;

    logic                   valid;
    logic                   ready;
    status_t                status;
    logic [COORD_BITS-1:0]  pixel_x;
    logic [COORD_BITS-1:0]  pixel_y;
    logic [OFFSET_BITS-1:0] frame_offset;
    logic [COLOR_BITS-1:0]  pixel_color;
    logic                   last;

    modport source (output valid, status, pixel_x, pixel_y, frame_offset, pixel_color,
                    last, input ready);
    modport sink   (input valid, status, pixel_x, pixel_y, frame_offset, pixel_color,
                    last, output ready);
endinterface

@@ rtl/bresenham_line_rasterizer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_top - all-octant Bresenham line engine
// Load / step command in, one pixel result (or reject / idle) out per item.
// ----------------------------------------------------------------------------
// The block takes one command item per clock while its first result register
// can take it, and gives exactly one result item for each. A load (action 0)
// checks both endpoints against screen_width and screen_height, answers with a
// reject or with the first pixel, and arms the line unless the endpoints
// coincide; each step (action 1) moves one pixel along it, flags the end point
// with last, and answers idle once no line is armed. Throughput is one item per
// clock while the input is not held off: the step is a single error-term
// add-and-compare done in the accept cycle. A result passes two registers:
// the first holds the pixel from the step logic, the second holds it
// with its frame offset width*y+x, formed by one multiply-add. Both registers
// are elastic, so up to two results may wait on a stalled output while the
// input keeps ready high until both are full. screen_width and screen_height
// reset to 640 and 480; write them only while no item is in flight (the user is bound, the block does not enforce it).
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_top #(
    parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF,
    parameter int COLOR_BITS = blr_pkg::COLOR_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    blr_cmd_if.sink                            cmd,
    blr_pix_if.source                          pix,
    input  logic                               cfg_we,
    input  logic [blr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS:0]                cfg_data
);
    import blr_pkg::*;

    // frame size registers
    logic [COORD_BITS:0]   width_reg;
    logic [COORD_BITS:0]   height_reg;

    // handshake
    logic                  accept;
    logic                  res_free;
    logic                  res_advance;
    logic                  out_free;
    logic                  out_valid_reg, out_valid_next;

    // first result register (from the line core)
    logic                  res_valid;
    pix_ctrl_t             res_ctrl;
    logic [COORD_BITS-1:0] res_x, res_y;
    logic [COLOR_BITS-1:0] res_color;

    pix_ctrl_t             out_ctrl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= (COORD_BITS+1)'(WIDTH_RESET);
            height_reg <= (COORD_BITS+1)'(HEIGHT_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // The output register frees when empty or taken this cycle; the first
    // register moves on into it and frees for a new item in the same cycle.
    assign out_free    = !out_valid_reg || pix.ready;
    assign res_advance = res_valid && out_free;
    assign res_free    = !res_valid || out_free;
    assign accept      = cmd.valid && res_free;
    assign cmd.ready   = res_free;

    blr_line_core #(
        .COORD_BITS (COORD_BITS),
        .COLOR_BITS (COLOR_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .advance       (res_advance),
        .action        (cmd.action),
        .start_x       (cmd.start_x),
        .start_y       (cmd.start_y),
        .end_x         (cmd.end_x),
        .end_y         (cmd.end_y),
        .color         (cmd.color),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .res_valid     (res_valid),
        .res_ctrl      (res_ctrl),
        .res_x         (res_x),
        .res_y         (res_y),
        .res_color     (res_color)
    );

    blr_out_stage #(
        .COORD_BITS (COORD_BITS),
        .COLOR_BITS (COLOR_BITS)
    ) u_out (
        .clk          (clk),
        .load         (res_advance),
        .in_ctrl      (res_ctrl),
        .in_x         (res_x),
        .in_y         (res_y),
        .in_color     (res_color),
        .screen_width (width_reg),
        .out_ctrl     (out_ctrl),
        .out_x        (pix.pixel_x),
        .out_y        (pix.pixel_y),
        .out_offset   (pix.frame_offset),
        .out_color    (pix.pixel_color)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (pix.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign pix.valid  = out_valid_reg;
    assign pix.status = out_ctrl.status;
    assign pix.last   = out_ctrl.last;

    // both result registers full and stalled: input must be held off
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && out_valid_reg && !pix.ready |-> !cmd.ready)
        else $error("input accepted with both result registers full");

    // an accepted item always lands in the first result register
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> res_valid)
        else $error("accepted item lost before first result register");

    // a moved-on result always shows on the output next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        res_advance |=> out_valid_reg)
        else $error("result lost between result registers");

    // reject and idle results carry no pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        pix.valid && (pix.status != ST_PIXEL) |->
            (pix.pixel_x == '0) && (pix.pixel_y == '0) && (pix.frame_offset == '0)
            && (pix.pixel_color == '0) && !pix.last)
        else $error("non-pixel result with pixel data");

endmodule

@@ rtl/blr_line_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blr_line_core - line state and Bresenham step
// Holds the running line and registers one pixel result per item.
// ----------------------------------------------------------------------------
module blr_line_core #(
    parameter int COORD_BITS = 12,
    parameter int COLOR_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic                   advance,
    input  logic                   action,
    input  logic [COORD_BITS:0]    start_x,
    input  logic [COORD_BITS:0]    start_y,
    input  logic [COORD_BITS:0]    end_x,
    input  logic [COORD_BITS:0]    end_y,
    input  logic [COLOR_BITS-1:0]  color,
    input  logic [COORD_BITS:0]    screen_width,
    input  logic [COORD_BITS:0]    screen_height,
    output logic                   res_valid,
    output blr_pkg::pix_ctrl_t     res_ctrl,
    output logic [COORD_BITS-1:0]  res_x,
    output logic [COORD_BITS-1:0]  res_y,
    output logic [COLOR_BITS-1:0]  res_color
);
    import blr_pkg::*;

    localparam int ERR_W = COORD_BITS + 3;
    localparam int E2_W  = ERR_W + 1;

    // line state
    logic                         line_active_reg, line_active_next;
    logic [COORD_BITS-1:0]        cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0]        cur_y_reg, cur_y_next;
    logic [COORD_BITS-1:0]        goal_x_reg, goal_x_next;
    logic [COORD_BITS-1:0]        goal_y_reg, goal_y_next;
    logic [COORD_BITS-1:0]        delta_x_reg, delta_x_next;
    logic signed [COORD_BITS:0]   neg_delta_y_reg, neg_delta_y_next;
    logic                         dir_x_reg, dir_x_next;
    logic                         dir_y_reg, dir_y_next;
    logic signed [ERR_W-1:0]      err_reg, err_next;
    logic [COLOR_BITS-1:0]        color_reg, color_next;

    // result register
    logic                         res_valid_reg, res_valid_next;
    pix_ctrl_t                    res_ctrl_reg, res_ctrl_next;
    logic [COORD_BITS-1:0]        res_x_reg, res_x_next;
    logic [COORD_BITS-1:0]        res_y_reg, res_y_next;
    logic [COLOR_BITS-1:0]        res_color_reg, res_color_next;

    // load path
    logic                         start_ok, end_ok, load_done;
    logic signed [COORD_BITS:0]   dx_diff, dy_diff, dx_neg, dy_neg;
    logic [COORD_BITS-1:0]        dx_abs, dy_abs;
    logic signed [ERR_W-1:0]      err_init;
    logic signed [COORD_BITS:0]   neg_dy_init;

    // step path
    logic signed [E2_W-1:0]       e2, neg_dy_ext, dx_ext;
    logic                         take_x, take_y, step_done;
    logic signed [ERR_W-1:0]      err_add_x, err_add_y, err_step;
    logic [COORD_BITS-1:0]        step_x, step_y;

    always_comb
    begin
        start_ok = !start_x[COORD_BITS] && !start_y[COORD_BITS]
                   && ({1'b0, start_x[COORD_BITS-1:0]} < screen_width)
                   && ({1'b0, start_y[COORD_BITS-1:0]} < screen_height);
        end_ok   = !end_x[COORD_BITS] && !end_y[COORD_BITS]
                   && ({1'b0, end_x[COORD_BITS-1:0]} < screen_width)
                   && ({1'b0, end_y[COORD_BITS-1:0]} < screen_height);

        dx_diff     = end_x - start_x;
        dy_diff     = end_y - start_y;
        dx_neg      = -dx_diff;
        dy_neg      = -dy_diff;
        dx_abs      = dx_diff[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx_diff[COORD_BITS-1:0];
        dy_abs      = dy_diff[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy_diff[COORD_BITS-1:0];
        err_init    = ERR_W'({1'b0, dx_abs}) - ERR_W'({1'b0, dy_abs});
        neg_dy_init = (COORD_BITS+1)'(0) - {1'b0, dy_abs};
        load_done   = (start_x[COORD_BITS-1:0] == end_x[COORD_BITS-1:0])
                      && (start_y[COORD_BITS-1:0] == end_y[COORD_BITS-1:0]);
    end

    always_comb
    begin
        e2         = {err_reg, 1'b0};
        neg_dy_ext = E2_W'(neg_delta_y_reg);
        dx_ext     = E2_W'({1'b0, delta_x_reg});
        take_x     = (e2 >= neg_dy_ext);
        take_y     = (e2 <= dx_ext);
        err_add_x  = take_x ? ERR_W'(neg_delta_y_reg) : '0;
        err_add_y  = take_y ? ERR_W'({1'b0, delta_x_reg}) : '0;
        err_step   = err_reg + err_add_x + err_add_y;
        step_x     = !take_x ? cur_x_reg : (dir_x_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1);
        step_y     = !take_y ? cur_y_reg : (dir_y_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1);
        step_done  = (step_x == goal_x_reg) && (step_y == goal_y_reg);
    end

    always_comb
    begin
        line_active_next = line_active_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        goal_x_next      = goal_x_reg;
        goal_y_next      = goal_y_reg;
        delta_x_next     = delta_x_reg;
        neg_delta_y_next = neg_delta_y_reg;
        dir_x_next       = dir_x_reg;
        dir_y_next       = dir_y_reg;
        err_next         = err_reg;
        color_next       = color_reg;

        res_valid_next   = res_valid_reg;
        res_ctrl_next    = res_ctrl_reg;
        res_x_next       = res_x_reg;
        res_y_next       = res_y_reg;
        res_color_next   = res_color_reg;

        if (advance)
        begin
            res_valid_next = 1'b0;
        end

        if (accept)
        begin
            res_valid_next        = 1'b1;
            res_ctrl_next.status  = ST_IDLE;
            res_ctrl_next.last    = 1'b0;
            res_x_next            = '0;
            res_y_next            = '0;
            res_color_next        = '0;

            if (action == ACT_LOAD)
            begin
                line_active_next = 1'b0;
                if (start_ok && end_ok)
                begin
                    cur_x_next       = start_x[COORD_BITS-1:0];
                    cur_y_next       = start_y[COORD_BITS-1:0];
                    goal_x_next      = end_x[COORD_BITS-1:0];
                    goal_y_next      = end_y[COORD_BITS-1:0];
                    delta_x_next     = dx_abs;
                    neg_delta_y_next = neg_dy_init;
                    dir_x_next       = dx_diff[COORD_BITS] || (dx_diff == '0);
                    dir_y_next       = dy_diff[COORD_BITS] || (dy_diff == '0);
                    err_next         = err_init;
                    color_next       = color;
                    line_active_next = !load_done;

                    res_ctrl_next.status = ST_PIXEL;
                    res_ctrl_next.last   = load_done;
                    res_x_next           = start_x[COORD_BITS-1:0];
                    res_y_next           = start_y[COORD_BITS-1:0];
                    res_color_next       = color;
                end
                else
                begin
                    res_ctrl_next.status = ST_REJECT;
                end
            end
            else if (line_active_reg)
            begin
                cur_x_next       = step_x;
                cur_y_next       = step_y;
                err_next         = err_step;
                line_active_next = !step_done;

                res_ctrl_next.status = ST_PIXEL;
                res_ctrl_next.last   = step_done;
                res_x_next           = step_x;
                res_y_next           = step_y;
                res_color_next       = color_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_active_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            line_active_reg <= line_active_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg       <= cur_x_next;
        cur_y_reg       <= cur_y_next;
        goal_x_reg      <= goal_x_next;
        goal_y_reg      <= goal_y_next;
        delta_x_reg     <= delta_x_next;
        neg_delta_y_reg <= neg_delta_y_next;
        dir_x_reg       <= dir_x_next;
        dir_y_reg       <= dir_y_next;
        err_reg         <= err_next;
        color_reg       <= color_next;
        res_ctrl_reg    <= res_ctrl_next;
        res_x_reg       <= res_x_next;
        res_y_reg       <= res_y_next;
        res_color_reg   <= res_color_next;
    end

    assign res_valid = res_valid_reg;
    assign res_ctrl  = res_ctrl_reg;
    assign res_x     = res_x_reg;
    assign res_y     = res_y_reg;
    assign res_color = res_color_reg;

endmodule

@@ rtl/blr_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blr_out_stage - output register with frame offset
// Forms width*y+x and holds the pixel for the downstream side.
// ----------------------------------------------------------------------------
module blr_out_stage #(
    parameter int COORD_BITS = 12,
    parameter int COLOR_BITS = 16
) (
    input  logic                            clk,
    input  logic                            load,
    input  blr_pkg::pix_ctrl_t              in_ctrl,
    input  logic [COORD_BITS-1:0]           in_x,
    input  logic [COORD_BITS-1:0]           in_y,
    input  logic [COLOR_BITS-1:0]           in_color,
    input  logic [COORD_BITS:0]             screen_width,
    output blr_pkg::pix_ctrl_t              out_ctrl,
    output logic [COORD_BITS-1:0]           out_x,
    output logic [COORD_BITS-1:0]           out_y,
    output logic [blr_pkg::OFFSET_BITS-1:0] out_offset,
    output logic [COLOR_BITS-1:0]           out_color
);
    import blr_pkg::*;

    localparam int SUM_W = (2*COORD_BITS + 2 > OFFSET_BITS) ? 2*COORD_BITS + 2 : OFFSET_BITS;

    logic [SUM_W-1:0]       offset_sum;
    pix_ctrl_t              ctrl_reg;
    logic [COORD_BITS-1:0]  x_reg, y_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [COLOR_BITS-1:0]  color_reg;

    // non-pixel results carry x = y = 0, so the offset comes out zero too
    assign offset_sum = SUM_W'(screen_width) * SUM_W'(in_y) + SUM_W'(in_x);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctrl_reg   <= in_ctrl;
            x_reg      <= in_x;
            y_reg      <= in_y;
            offset_reg <= offset_sum[OFFSET_BITS-1:0];
            color_reg  <= in_color;
        end
    end

    assign out_ctrl   = ctrl_reg;
    assign out_x      = x_reg;
    assign out_y      = y_reg;
    assign out_offset = offset_reg;
    assign out_color  = color_reg;

endmodule

@@ test/bresenham_line_rasterizer_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_top_tb - self-checking bench for the line engine
// Drives load/step items with random gaps and output stalls. A local
// Bresenham model predicts each pixel, reject or idle result, and a monitor
// compares every result item field by field. Frame size is swept between
// phases, including zero, single-pixel, full and oversized frames.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_top_tb;
    import blr_pkg::*;

    localparam int CB           = COORD_BITS_DEF;
    localparam int CLB          = COLOR_BITS_DEF;
    localparam int IDLE_PCT     = 22;     // per-cycle chance of a gap on either side
    localparam int DRAIN_CYCLES = 6;      // two-stage pipe plus margin
    localparam int HOLD_CYCLES  = 80;     // long output stall for the fill-up test
    localparam int RANDOM_ITEMS = 1200;

    typedef logic [CB:0]    coord_in_t;   // signed 13-bit input coordinate
    typedef logic [CB-1:0]  coord_t;
    typedef logic [CLB-1:0] color_t;

    typedef struct packed {
        status_t                status;
        coord_t                 x;
        coord_t                 y;
        logic [OFFSET_BITS-1:0] offset;
        color_t                 color;
        logic                   last;
    } pixel_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    coord_in_t  cfg_data;

    blr_cmd_if #(.COORD_BITS(CB), .COLOR_BITS(CLB)) cmd_ch ();
    blr_pix_if #(.COORD_BITS(CB), .COLOR_BITS(CLB)) pix_ch ();

    bresenham_line_rasterizer_top #(
        .COORD_BITS (CB),
        .COLOR_BITS (CLB)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .pix       (pix_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Results still owed by the block, oldest first.
    pixel_t pending_pixels[$];
    int     mismatch_count = 0;
    int     items_sent     = 0;

    // Traffic shaping knobs shared with the output process.
    bit     src_steady  = 0;
    bit     sink_steady = 0;
    int     hold_left   = 0;

    // Local copy of the frame size and the line walker state.
    coord_in_t scr_w = coord_in_t'(WIDTH_RESET);
    coord_in_t scr_h = coord_in_t'(HEIGHT_RESET);
    bit        line_on = 0;
    coord_t    cur_px = '0, cur_py = '0, goal_px = '0, goal_py = '0;
    int        abs_dx = 0, neg_dy = 0, err_acc = 0;
    bit        x_down = 0, y_down = 0;
    color_t    line_col = '0;

    // ------------------------------------------------------------------------
    // Clock, 2 ns period.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #1000000;
        $display("bresenham_line_rasterizer_top: mismatch");
        $finish;
    end

    function automatic bit in_frame(input int x, input int y);
        return x >= 0 && y >= 0 && x < int'(scr_w) && y < int'(scr_h);
    endfunction

    // ------------------------------------------------------------------------
    // Predict the result of one accepted item and queue it. Load checks both
    // endpoints, arms the walker and emits the start pixel; a step moves by
    // the doubled error term against -|dy| and |dx|.
    // ------------------------------------------------------------------------
    task automatic rasterize_item(input action_t act, input coord_in_t x1r, y1r, x2r, y2r,
                                  input color_t col);
        pixel_t      p;
        int          x1, y1, x2, y2, e2;
        bit          emit;
        logic [31:0] off;
        p    = '0;
        emit = 0;
        if (act == ACT_LOAD)
        begin
            x1 = $signed(x1r);
            y1 = $signed(y1r);
            x2 = $signed(x2r);
            y2 = $signed(y2r);
            line_on = 0;    // any load drops the running line
            if (!in_frame(x1, y1) || !in_frame(x2, y2))
                p.status = ST_REJECT;
            else
            begin
                abs_dx   = (x2 > x1) ? x2 - x1 : x1 - x2;
                neg_dy   = (y2 > y1) ? y1 - y2 : y2 - y1;
                x_down   = !(x1 < x2);
                y_down   = !(y1 < y2);
                err_acc  = abs_dx + neg_dy;
                cur_px   = coord_t'(x1);
                cur_py   = coord_t'(y1);
                goal_px  = coord_t'(x2);
                goal_py  = coord_t'(y2);
                line_col = col;
                emit     = 1;
            end
        end
        else if (!line_on)
            p.status = ST_IDLE;
        else
        begin
            e2 = 2 * err_acc;
            if (e2 >= neg_dy)
            begin
                err_acc += neg_dy;
                cur_px  = x_down ? cur_px - 1'b1 : cur_px + 1'b1;
            end
            if (e2 <= abs_dx)
            begin
                err_acc += abs_dx;
                cur_py  = y_down ? cur_py - 1'b1 : cur_py + 1'b1;
            end
            emit = 1;
        end

        if (emit)
        begin
            off      = 32'(scr_w) * 32'(cur_py) + 32'(cur_px);
            p.status = ST_PIXEL;
            p.x      = cur_px;
            p.y      = cur_py;
            p.offset = off[OFFSET_BITS-1:0];
            p.color  = line_col;
            p.last   = (cur_px == goal_px) && (cur_py == goal_py);
            line_on  = !p.last;
        end
        pending_pixels.push_back(p);
    endtask

    // ------------------------------------------------------------------------
    // Offer one item, starting at a falling edge. Valid stays high after the
    // handshake so back-to-back items never toggle it within one time step.
    // ------------------------------------------------------------------------
    task automatic send_item(input action_t act, input coord_in_t x1, y1, x2, y2,
                             input color_t col);
        while (!src_steady && $urandom_range(99) < IDLE_PCT)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.action  <= act;
        cmd_ch.start_x <= x1;
        cmd_ch.start_y <= y1;
        cmd_ch.end_x   <= x2;
        cmd_ch.end_y   <= y2;
        cmd_ch.color   <= col;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        rasterize_item(act, x1, y1, x2, y2, col);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_load(input int x1, y1, x2, y2, input color_t col);
        send_item(ACT_LOAD, coord_in_t'(x1), coord_in_t'(y1), coord_in_t'(x2),
                  coord_in_t'(y2), col);
    endtask

    // Endpoint fields are don't-care on a step; fill them with noise.
    task automatic send_step();
        send_item(ACT_STEP, coord_in_t'($urandom), coord_in_t'($urandom),
                  coord_in_t'($urandom), coord_in_t'($urandom), color_t'($urandom));
    endtask

    task automatic trace_line();
        while (line_on)
            send_step();
    endtask

    // Stop offering and let every owed result come out.
    task automatic wait_drain();
        cmd_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int value);
        wait_drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= coord_in_t'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_SCREEN_WIDTH)
            scr_w = coord_in_t'(value);
        else
            scr_h = coord_in_t'(value);
    endtask

    task automatic set_frame(input int w, input int h);
        write_reg(REG_SCREEN_WIDTH, w);
        write_reg(REG_SCREEN_HEIGHT, h);
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stalls, a counted long hold when requested.
    // ------------------------------------------------------------------------
    initial
    begin
        pix_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                pix_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (sink_steady)
                pix_ch.ready <= 1'b1;
            else
                pix_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want, got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Result monitor: every accepted result against the oldest prediction.
    initial
    begin
        pixel_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && pix_ch.valid === 1'b1 && pix_ch.ready)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $error("result item with nothing expected");
                    mismatch_count++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    check_field("status", 32'(want.status), 32'(pix_ch.status));
                    check_field("pixel_x", 32'(want.x), 32'(pix_ch.pixel_x));
                    check_field("pixel_y", 32'(want.y), 32'(pix_ch.pixel_y));
                    check_field("frame_offset", 32'(want.offset), 32'(pix_ch.frame_offset));
                    check_field("pixel_color", 32'(want.color), 32'(pix_ch.pixel_color));
                    check_field("last", 32'(want.last), 32'(pix_ch.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // A step right after reset has no line to walk.
    task automatic test_idle_after_reset();
        send_step();
    endtask

    // Coinciding endpoints: one pixel, flagged last, nothing left armed.
    task automatic test_single_point();
        send_load(0, 0, 0, 0, '0);
        send_step();
        send_load(WIDTH_RESET - 1, HEIGHT_RESET - 1, WIDTH_RESET - 1, HEIGHT_RESET - 1, '1);
        send_step();
    endtask

    // Short lines in mixed directions, both shallow and steep.
    task automatic test_octants();
        send_load(320, 240, 322, 241, 16'h1234);
        trace_line();
        send_load(320, 240, 319, 238, 16'hA5A5);
        trace_line();
        send_load(WIDTH_RESET - 1, HEIGHT_RESET - 1, WIDTH_RESET - 3, HEIGHT_RESET - 2,
                  16'hFFFF);
        trace_line();
    endtask

    // Out-of-frame loads reject and kill the line that was running.
    task automatic test_rejects();
        send_load(1, 1, 3, 3, 16'h00FF);
        send_step();
        send_load(-1, 0, 5, 5, 16'hFFFF);
        send_step();
        send_load(0, 0, WIDTH_RESET, 0, 16'h0F0F);
        send_load(0, HEIGHT_RESET, 0, 0, 16'hF0F0);
        send_load(-4096, -4096, 4095, 4095, 16'hFFFF);
    endtask

    // A new load mid-line replaces it.
    task automatic test_load_during_line();
        send_load(10, 10, 20, 12, 16'h5555);
        send_step();
        send_load(5, 5, 3, 9, 16'hAAAA);
        trace_line();
    endtask

    // Frame size corners: zero width/height, 1x1, full 4096, oversized width.
    task automatic test_frame_sizes();
        set_frame(0, HEIGHT_RESET);
        send_load(0, 0, 0, 0, 16'h0001);
        set_frame(WIDTH_RESET, 0);
        send_load(0, 0, 0, 0, 16'h0002);
        set_frame(1, 1);
        send_load(0, 0, 0, 0, 16'h0003);
        send_load(0, 0, 1, 0, 16'h0004);
        set_frame(4096, 4096);
        send_load(4095, 4095, 4093, 4094, 16'h8000);
        trace_line();
        set_frame(8191, 4096);              // offset wraps past 24 bits
        send_load(4095, 4095, 4094, 4093, 16'h7FFF);
        trace_line();
        set_frame(WIDTH_RESET, HEIGHT_RESET);
    endtask

    // Output held off while the input keeps offering: the pipe must fill and
    // push back, then drain in order.
    task automatic test_backpressure();
        src_steady = 1;
        wait_drain();
        hold_left = HOLD_CYCLES;
        send_load(100, 100, 130, 90, 16'hC0DE);
        trace_line();
        src_steady = 0;
        wait_drain();
    endtask

    // ------------------------------------------------------------------------
    // Random lines. Mostly well-formed loads walked to the end, sometimes
    // cut short by a new load; the rest is raw noise loads and stray steps.
    // ------------------------------------------------------------------------
    task automatic random_line();
        int w, h, x1, y1, x2, y2, span;
        w = (int'(scr_w) > 4096) ? 4096 : int'(scr_w);
        h = (int'(scr_h) > 4096) ? 4096 : int'(scr_h);
        if (w == 0 || h == 0)
        begin
            send_load(0, 0, 0, 0, color_t'($urandom));
            return;
        end
        x1 = ($urandom_range(9) == 0) ? (($urandom_range(1) == 0) ? 0 : w - 1)
                                      : $urandom_range(w - 1);
        y1 = ($urandom_range(9) == 0) ? (($urandom_range(1) == 0) ? 0 : h - 1)
                                      : $urandom_range(h - 1);
        span = ($urandom_range(99) < 92) ? $urandom_range(12) : $urandom_range(400);
        x2 = x1 + $urandom_range(2 * span) - span;
        y2 = y1 + $urandom_range(2 * span) - span;
        x2 = (x2 < 0) ? 0 : (x2 > w - 1) ? w - 1 : x2;
        y2 = (y2 < 0) ? 0 : (y2 > h - 1) ? h - 1 : y2;
        send_load(x1, y1, x2, y2, color_t'($urandom));
        while (line_on && $urandom_range(99) >= 3)
            send_step();
        if (!line_on && $urandom_range(99) < 20)
            repeat ($urandom_range(1, 2)) send_step();
    endtask

    task automatic random_items(input int count);
        int stop_at, roll;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            roll = $urandom_range(99);
            if (roll < 78)
                random_line();
            else if (roll < 92)
                send_item(ACT_LOAD, coord_in_t'($urandom), coord_in_t'($urandom),
                          coord_in_t'($urandom), coord_in_t'($urandom), color_t'($urandom));
            else
                send_step();
        end
    endtask

    task automatic pick_random_frame();
        case ($urandom_range(6))
            0: set_frame(WIDTH_RESET, HEIGHT_RESET);
            1: set_frame(4096, 4096);
            2: set_frame($urandom_range(1, 8), $urandom_range(1, 8));
            3: set_frame($urandom_range(4097, 8191), $urandom_range(1, 4096));
            4: set_frame($urandom_range(1) ? 0 : $urandom_range(1, 4096),
                         $urandom_range(1) ? 0 : $urandom_range(1, 4096));
            default: set_frame($urandom_range(1, 4096), $urandom_range(1, 4096));
        endcase
    endtask

    // No gaps on either side for a stretch.
    task automatic test_steady_stream();
        src_steady  = 1;
        sink_steady = 1;
        set_frame(4096, 4096);
        random_items(150);
        wait_drain();
        src_steady  = 0;
        sink_steady = 0;
    endtask

    task automatic test_random(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            pick_random_frame();
            random_items(120);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.action  = ACT_LOAD;
        cmd_ch.start_x = '0;
        cmd_ch.start_y = '0;
        cmd_ch.end_x   = '0;
        cmd_ch.end_y   = '0;
        cmd_ch.color   = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_idle_after_reset();
        test_single_point();
        test_octants();
        test_rejects();
        test_load_during_line();
        test_frame_sizes();
        test_backpressure();
        test_steady_stream();
        test_random(RANDOM_ITEMS);

        wait_drain();
        if (mismatch_count == 0)
            $display("bresenham_line_rasterizer_top: match");
        else
            $display("bresenham_line_rasterizer_top: mismatch");
        $finish;
    end

endmodule
